// ----- sv/scrl_pkg.sv -----
// Shared constants for the sticky-code linear repair block.
// Holds field widths, the run-buffer sizing and the stuck-code patterns.
// Depends on nothing.
package scrl_pkg;

    // Run buffer depth and usable sample bits
    localparam int MAX_RUN     = 32;
    localparam int SAMPLE_BITS = 12;

    // Fixed field widths
    localparam int SAMPLE_W = 12;
    localparam int CHAN_W   = 14;
    localparam int FRAC_W   = 6;
    localparam int VALUE_W  = SAMPLE_W + FRAC_W;

    localparam int S_USE_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] S_MASK = SAMPLE_W'((1 << S_USE_W) - 1);

    // Run bookkeeping widths
    localparam int RUN_W = $clog2(MAX_RUN + 1);   // run length, 0..MAX_RUN
    localparam int ADDR_W = $clog2(MAX_RUN);      // buffer address
    localparam int N_W   = $clog2(MAX_RUN + 2);   // run length + 1

    // Interpolation datapath widths
    localparam int A_W   = SAMPLE_W + N_W;        // left*(n-j) + right*j
    localparam int D_W   = A_W + FRAC_W + 1;      // 2*64*A + n
    localparam int DV_W  = $clog2(2 * MAX_RUN + 3); // divisor 2*n
    localparam int Q_W   = VALUE_W;               // quotient bits
    localparam int BIT_W = $clog2(Q_W);

    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(((1 << SAMPLE_W) - 1) << FRAC_W);

    // Low-bit patterns of a suspected stuck ADC code
    localparam logic [FRAC_W-1:0] CODE_ZERO = FRAC_W'(0);
    localparam logic [FRAC_W-1:0] CODE_ONE  = FRAC_W'(1);
    localparam logic [FRAC_W-1:0] CODE_TOP  = FRAC_W'(63);

endpackage

// ----- sv/sticky_code_linear_repair_core.sv -----
// Top level of the sticky-code linear repair block.
// Depends on scrl_pkg and on the scrl_ram buffer memory.
//
// Repairs suspected stuck ADC codes (low six bits 0, 1 or 63) in one waveform at a time.
// A run of stuck ticks between two good ticks is held in a MAX_RUN-deep buffer and replaced
// by a straight line between the neighbors, in unsigned fixed point with 6 fraction bits,
// rounded to nearest with halves up; all other ticks pass through scaled by 64. Each request
// on the input stream makes zero or more result requests; tlast marks the last one of an input
// and tuser[1] the last one of a waveform. A stuck tick that is held gives no result; a tick
// that passes straight through is written to the output register from ST_SELF; a flush of k
// held codes followed by the tick takes one buffer read and one output write per code; every
// interpolated point of a run closed by a good tick goes through one shared restoring divider
// that retires one quotient bit per cycle (a load, one step per quotient bit, a write). The input
// is not ready while an item is at work. One output register parts the sides, so a new input
// is taken while the previous result still waits. The buffer needs no clearing after reset.
module sticky_code_linear_repair_core
    import scrl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [11:0] sample, [25:12] channel, [31:26] zero
    input  logic        i_s_axis_tlast,   // waveform_end
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [17:0] value, [31:18] channel_out
    output logic [1:0]  o_m_axis_tuser,   // [0] repaired, [1] waveform_done
    output logic        o_m_axis_tlast    // run_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FL_RD,
        ST_FL_WR,
        ST_DV_LD,
        ST_DV_RUN,
        ST_DV_WR,
        ST_SELF
    } t_state;

    t_state r_state;

    // waveform state
    logic [RUN_W-1:0]    r_len;
    logic [SAMPLE_W-1:0] r_left;
    logic                r_have_left;
    logic                r_ovf;

    // current request
    logic [SAMPLE_W-1:0] r_s;
    logic [CHAN_W-1:0]   r_chan;
    logic                r_stuck;
    logic                r_last;
    logic                r_set_ovf;
    logic [RUN_W-1:0]    r_idx;

    // interpolation and divider
    logic [A_W-1:0]   r_acc;
    logic [DV_W-1:0]  r_dv;
    logic [DV_W-1:0]  r_rem;
    logic [Q_W-1:0]   r_qs;
    logic [BIT_W-1:0] r_bit;

    // output register
    logic               r_m_valid;
    logic [VALUE_W-1:0] r_m_value;
    logic [CHAN_W-1:0]  r_m_chan;
    logic               r_m_rep;
    logic               r_m_last;
    logic               r_m_done;

    logic [SAMPLE_W-1:0]       w_s;
    logic                      w_stuck;
    logic                      w_acc_in;
    logic                      w_free;
    logic                      w_out_wr;
    logic                      w_hold;
    logic [N_W-1:0]            w_n;
    logic [SAMPLE_W+RUN_W-1:0] w_prod;
    logic [A_W-1:0]            w_acc0;
    logic [A_W-1:0]            w_step;
    logic [D_W-1:0]            w_dvd;
    logic [DV_W:0]             w_trial;
    logic [DV_W:0]             w_diff;
    logic                      w_ge;
    logic [SAMPLE_W-1:0]       w_rdata;
    logic                      w_idx_end;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_acc_in        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_free          = !r_m_valid || i_m_axis_tready;
    // a new result is loaded into the output register this cycle
    assign w_out_wr        = w_free && ((r_state == ST_FL_WR) || (r_state == ST_DV_WR) ||
                                        (r_state == ST_SELF));

    // Classify the incoming code
    always_comb begin
        w_s     = i_s_axis_tdata[SAMPLE_W-1:0] & S_MASK;
        w_stuck = (w_s[FRAC_W-1:0] == CODE_ZERO) || (w_s[FRAC_W-1:0] == CODE_ONE) ||
                  (w_s[FRAC_W-1:0] == CODE_TOP);
    end

    // Hold a stuck code in the buffer when a left neighbor exists, room remains, no overflow is set and tlast is low
    assign w_hold = w_acc_in && w_stuck && r_have_left && !r_ovf && !i_s_axis_tlast &&
                    (r_len < RUN_W'(MAX_RUN));

    // Interpolation numerator: start at left*L + right, step by right - left
    assign w_n    = N_W'(r_len) + N_W'(1);
    assign w_prod = r_left * r_len;
    assign w_acc0 = A_W'(w_prod) + A_W'(w_s);
    assign w_step = r_acc + A_W'(r_s) - A_W'(r_left);
    // Dividend 2*64*A + n, rounded to nearest by the divisor 2*n
    assign w_dvd  = {r_acc, {(FRAC_W + 1){1'b0}}} + D_W'(w_n);

    // One restoring step of the shared divider
    assign w_trial = {r_rem, r_qs[Q_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dv});
    assign w_diff  = w_trial - {1'b0, r_dv};

    assign w_idx_end = ((r_idx + RUN_W'(1)) == r_len);

    scrl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_RUN)
    ) u_run_buf (
        .i_clk   (i_clk),
        .i_we    (w_hold),
        .i_waddr (r_len[ADDR_W-1:0]),
        .i_wdata (w_s),
        .i_re    (r_state == ST_FL_RD),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_left      <= '0;
            r_have_left <= 1'b0;
            r_ovf       <= 1'b0;
            r_set_ovf   <= 1'b0;
            r_chan      <= '0;
            r_idx       <= '0;
            r_bit       <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            // drop the result once it is taken, unless a new one is loaded this cycle
            if (i_m_axis_tready && !w_out_wr) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc_in) begin
                        r_s       <= w_s;
                        r_chan    <= i_s_axis_tdata[SAMPLE_W+CHAN_W-1:SAMPLE_W];
                        r_stuck   <= w_stuck;
                        r_last    <= i_s_axis_tlast;
                        r_idx     <= '0;
                        r_set_ovf <= 1'b0;
                        if (w_stuck) begin
                            if (!r_have_left || r_ovf) begin
                                // waveform start or overflowed run: pass through
                                r_state <= ST_SELF;
                            end else if (r_len >= RUN_W'(MAX_RUN)) begin
                                // buffer full: flush unchanged, then overflow
                                r_set_ovf <= 1'b1;
                                r_state   <= ST_FL_RD;
                            end else if (i_s_axis_tlast) begin
                                // run at waveform end: flush unchanged
                                r_state <= (r_len == '0) ? ST_SELF : ST_FL_RD;
                            end else begin
                                r_len <= r_len + RUN_W'(1);
                            end
                        end else begin
                            r_acc   <= w_acc0;
                            r_dv    <= DV_W'({w_n, 1'b0});
                            r_state <= (r_len != '0 && r_have_left) ? ST_DV_LD : ST_SELF;
                        end
                    end
                end

                ST_FL_RD: begin
                    r_state <= ST_FL_WR;
                end

                ST_FL_WR: begin
                    if (w_free) begin
                        r_m_valid <= 1'b1;
                        r_m_value <= {w_rdata, {FRAC_W{1'b0}}};
                        r_m_chan  <= r_chan;
                        r_m_rep   <= 1'b0;
                        r_m_last  <= 1'b0;
                        r_m_done  <= 1'b0;
                        r_idx     <= r_idx + RUN_W'(1);
                        r_state   <= w_idx_end ? ST_SELF : ST_FL_RD;
                    end
                end

                ST_DV_LD: begin
                    r_rem   <= DV_W'(w_dvd >> Q_W);
                    r_qs    <= w_dvd[Q_W-1:0];
                    r_bit   <= '0;
                    r_state <= ST_DV_RUN;
                end

                ST_DV_RUN: begin
                    r_rem <= w_ge ? w_diff[DV_W-1:0] : w_trial[DV_W-1:0];
                    r_qs  <= {r_qs[Q_W-2:0], w_ge};
                    r_bit <= r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(Q_W - 1)) begin
                        r_state <= ST_DV_WR;
                    end
                end

                ST_DV_WR: begin
                    if (w_free) begin
                        r_m_valid <= 1'b1;
                        r_m_value <= r_qs;
                        r_m_chan  <= r_chan;
                        r_m_rep   <= 1'b1;
                        r_m_last  <= 1'b0;
                        r_m_done  <= 1'b0;
                        r_acc     <= w_step;
                        r_idx     <= r_idx + RUN_W'(1);
                        r_state   <= w_idx_end ? ST_SELF : ST_DV_LD;
                    end
                end

                ST_SELF: begin
                    if (w_free) begin
                        r_m_valid <= 1'b1;
                        r_m_value <= {r_s, {FRAC_W{1'b0}}};
                        r_m_chan  <= r_chan;
                        r_m_rep   <= 1'b0;
                        r_m_last  <= 1'b1;
                        r_m_done  <= r_last;
                        // close the request and advance the waveform state
                        r_len <= '0;
                        if (!r_stuck) begin
                            r_left <= r_s;
                        end
                        if (r_last) begin
                            r_have_left <= 1'b0;
                            r_ovf       <= 1'b0;
                        end else if (!r_stuck) begin
                            r_have_left <= 1'b1;
                            r_ovf       <= 1'b0;
                        end else if (r_set_ovf) begin
                            r_ovf <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_chan, r_m_value};
    assign o_m_axis_tuser  = {r_m_done, r_m_rep};
    assign o_m_axis_tlast  = r_m_last;

    // The run never outgrows the buffer
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= RUN_W'(MAX_RUN))
        else $error("run length beyond buffer depth");

    // Held codes imply a left neighbor for the line
    a_len_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) |-> r_have_left)
        else $error("codes held without a left neighbor");

    // Interpolated points stay within the scaled sample range
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DV_WR) |-> (r_qs <= VALUE_MAX))
        else $error("interpolated value out of range");

    // The end of a waveform is always the last result of its request
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tlast)
        else $error("waveform end flagged on a non-final result");

endmodule

// ----- sv/scrl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the held stuck-code buffer. Depends on nothing.
module scrl_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
